[sv/rv32i_dec_pkg.sv]
// Package with the transaction types and decode constants of the RV32I instruction decoder.
`timescale 1ns / 1ps

package rv32i_dec_pkg;

    typedef struct packed {
        logic [31:0] instr_word;
    } t_dec_in;

    typedef struct packed {
        logic [3:0]         format_class;
        logic [5:0]         operation;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [3:0]         fence_pred;
        logic [3:0]         fence_succ;
    } t_dec_out;

    localparam logic [6:0] OPC_OP       = 7'b0110011;
    localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
    localparam logic [6:0] OPC_LOAD     = 7'b0000011;
    localparam logic [6:0] OPC_JALR     = 7'b1100111;
    localparam logic [6:0] OPC_STORE    = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
    localparam logic [6:0] OPC_LUI      = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
    localparam logic [6:0] OPC_JAL      = 7'b1101111;
    localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [3:0] FMT_UNDEF = 4'd0;
    localparam logic [3:0] FMT_R     = 4'd1;
    localparam logic [3:0] FMT_I     = 4'd2;
    localparam logic [3:0] FMT_S     = 4'd3;
    localparam logic [3:0] FMT_B     = 4'd4;
    localparam logic [3:0] FMT_U     = 4'd5;
    localparam logic [3:0] FMT_J     = 4'd6;
    localparam logic [3:0] FMT_FENCE = 4'd7;
    localparam logic [3:0] FMT_ENV   = 4'd8;

    localparam logic [5:0] OP_NONE   = 6'd0;
    localparam logic [5:0] OP_ADD    = 6'd1;
    localparam logic [5:0] OP_SUB    = 6'd2;
    localparam logic [5:0] OP_SLL    = 6'd3;
    localparam logic [5:0] OP_SLT    = 6'd4;
    localparam logic [5:0] OP_SLTU   = 6'd5;
    localparam logic [5:0] OP_XOR    = 6'd6;
    localparam logic [5:0] OP_SRL    = 6'd7;
    localparam logic [5:0] OP_SRA    = 6'd8;
    localparam logic [5:0] OP_OR     = 6'd9;
    localparam logic [5:0] OP_AND    = 6'd10;
    localparam logic [5:0] OP_ADDI   = 6'd11;
    localparam logic [5:0] OP_SLLI   = 6'd12;
    localparam logic [5:0] OP_SLTI   = 6'd13;
    localparam logic [5:0] OP_SLTIU  = 6'd14;
    localparam logic [5:0] OP_XORI   = 6'd15;
    localparam logic [5:0] OP_SRLI   = 6'd16;
    localparam logic [5:0] OP_SRAI   = 6'd17;
    localparam logic [5:0] OP_ORI    = 6'd18;
    localparam logic [5:0] OP_ANDI   = 6'd19;
    localparam logic [5:0] OP_LB     = 6'd20;
    localparam logic [5:0] OP_LH     = 6'd21;
    localparam logic [5:0] OP_LW     = 6'd22;
    localparam logic [5:0] OP_LBU    = 6'd23;
    localparam logic [5:0] OP_LHU    = 6'd24;
    localparam logic [5:0] OP_JALR   = 6'd25;
    localparam logic [5:0] OP_SB     = 6'd26;
    localparam logic [5:0] OP_SH     = 6'd27;
    localparam logic [5:0] OP_SW     = 6'd28;
    localparam logic [5:0] OP_BEQ    = 6'd29;
    localparam logic [5:0] OP_BNE    = 6'd30;
    localparam logic [5:0] OP_BLT    = 6'd31;
    localparam logic [5:0] OP_BGE    = 6'd32;
    localparam logic [5:0] OP_BLTU   = 6'd33;
    localparam logic [5:0] OP_BGEU   = 6'd34;
    localparam logic [5:0] OP_LUI    = 6'd35;
    localparam logic [5:0] OP_AUIPC  = 6'd36;
    localparam logic [5:0] OP_JAL    = 6'd37;
    localparam logic [5:0] OP_FENCE  = 6'd38;
    localparam logic [5:0] OP_FENCEI = 6'd39;
    localparam logic [5:0] OP_ECALL  = 6'd40;
    localparam logic [5:0] OP_EBREAK = 6'd41;

    function automatic logic [5:0] f_op_reg(input logic [2:0] f3);
        logic [5:0] v_op;
        unique case (f3)
            3'd0:    v_op = OP_ADD;
            3'd1:    v_op = OP_SLL;
            3'd2:    v_op = OP_SLT;
            3'd3:    v_op = OP_SLTU;
            3'd4:    v_op = OP_XOR;
            3'd5:    v_op = OP_SRL;
            3'd6:    v_op = OP_OR;
            default: v_op = OP_AND;
        endcase
        return v_op;
    endfunction

    function automatic logic [5:0] f_op_imm(input logic [2:0] f3);
        logic [5:0] v_op;
        unique case (f3)
            3'd0:    v_op = OP_ADDI;
            3'd2:    v_op = OP_SLTI;
            3'd3:    v_op = OP_SLTIU;
            3'd4:    v_op = OP_XORI;
            3'd6:    v_op = OP_ORI;
            3'd7:    v_op = OP_ANDI;
            default: v_op = OP_NONE;
        endcase
        return v_op;
    endfunction

    function automatic logic [5:0] f_op_load(input logic [2:0] f3);
        logic [5:0] v_op;
        unique case (f3)
            3'd0:    v_op = OP_LB;
            3'd1:    v_op = OP_LH;
            3'd2:    v_op = OP_LW;
            3'd4:    v_op = OP_LBU;
            3'd5:    v_op = OP_LHU;
            default: v_op = OP_NONE;
        endcase
        return v_op;
    endfunction

    function automatic logic [5:0] f_op_store(input logic [2:0] f3);
        logic [5:0] v_op;
        unique case (f3)
            3'd0:    v_op = OP_SB;
            3'd1:    v_op = OP_SH;
            3'd2:    v_op = OP_SW;
            default: v_op = OP_NONE;
        endcase
        return v_op;
    endfunction

    function automatic logic [5:0] f_op_branch(input logic [2:0] f3);
        logic [5:0] v_op;
        unique case (f3)
            3'd0:    v_op = OP_BEQ;
            3'd1:    v_op = OP_BNE;
            3'd4:    v_op = OP_BLT;
            3'd5:    v_op = OP_BGE;
            3'd6:    v_op = OP_BLTU;
            3'd7:    v_op = OP_BGEU;
            default: v_op = OP_NONE;
        endcase
        return v_op;
    endfunction

endpackage

[sv/rv32i_dec_stream_if.sv]
// Valid/ready channel interface that carries one decoder transaction.
`timescale 1ns / 1ps

interface rv32i_dec_stream_if
    import rv32i_dec_pkg::*;
#(
    parameter type t_payload = t_dec_in
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[sv/rv32i_instruction_decoder_top.sv]
// Top level of the RV32I instruction decoder with input and result registers.
// A word is held in the input register, decoded, then held in the result register.
// Throughput: one instruction per cycle unless o_dec stalls; the input and result
// registers form a two-stage pipeline; ready propagates back from the result register.
// Reset: synchronous, active low; it empties both stages but does not clear their data.
`timescale 1ns / 1ps

module rv32i_instruction_decoder_top
    import rv32i_dec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rv32i_dec_stream_if.sink          i_instr,
    rv32i_dec_stream_if.source        o_dec
);

    logic      r_in_valid;
    logic [31:0] r_word;
    logic      r_out_valid;
    t_dec_out  r_out;
    t_dec_out  n_out;
    logic      w_out_ready;
    logic      w_in_ready;

    logic [6:0]  w_opc;
    logic [4:0]  w_rd;
    logic [2:0]  w_f3;
    logic [4:0]  w_rs1;
    logic [4:0]  w_rs2;
    logic [6:0]  w_f7;
    logic [31:0] w_imm_i;
    logic [31:0] w_imm_s;
    logic [31:0] w_imm_b;
    logic [31:0] w_imm_j;
    logic [5:0]  w_op_tmp;

    assign w_out_ready = !r_out_valid || o_dec.ready;
    assign w_in_ready  = !r_in_valid || w_out_ready;

    assign i_instr.ready = w_in_ready;
    assign o_dec.valid   = r_out_valid;
    assign o_dec.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_instr.valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_instr.valid) begin
            r_word <= i_instr.payload.instr_word;
        end
        if (w_out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign w_opc   = r_word[6:0];
    assign w_rd    = r_word[11:7];
    assign w_f3    = r_word[14:12];
    assign w_rs1   = r_word[19:15];
    assign w_rs2   = r_word[24:20];
    assign w_f7    = r_word[31:25];
    assign w_imm_i = {{20{r_word[31]}}, r_word[31:20]};
    assign w_imm_s = {{20{r_word[31]}}, r_word[31:25], r_word[11:7]};
    assign w_imm_b = {{19{r_word[31]}}, r_word[31], r_word[7], r_word[30:25],
                      r_word[11:8], 1'b0};
    assign w_imm_j = {{11{r_word[31]}}, r_word[31], r_word[19:12], r_word[20],
                      r_word[30:21], 1'b0};

    always_comb begin
        n_out    = '0;
        w_op_tmp = OP_NONE;
        unique case (w_opc)
            OPC_OP: begin
                n_out.format_class = FMT_R;
                n_out.dest_reg     = w_rd;
                n_out.src1_reg     = w_rs1;
                n_out.src2_reg     = w_rs2;
                if (w_f7 == F7_ZERO) begin
                    n_out.operation = f_op_reg(w_f3);
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    n_out.operation = OP_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    n_out.operation = OP_SRA;
                end
            end
            OPC_OP_IMM: begin
                n_out.dest_reg  = w_rd;
                n_out.src1_reg  = w_rs1;
                n_out.immediate = w_imm_i;
                if (w_f3 == 3'd1 || w_f3 == 3'd5) begin
                    if (w_f7 == F7_ZERO) begin
                        w_op_tmp = (w_f3 == 3'd1) ? OP_SLLI : OP_SRLI;
                    end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                        w_op_tmp = OP_SRAI;
                    end
                    n_out.operation = w_op_tmp;
                    if (w_op_tmp != OP_NONE) begin
                        n_out.format_class = FMT_R;
                        n_out.src2_reg     = w_rs2;
                    end
                end else begin
                    n_out.format_class = FMT_I;
                    n_out.operation    = f_op_imm(w_f3);
                end
            end
            OPC_LOAD: begin
                n_out.dest_reg     = w_rd;
                n_out.src1_reg     = w_rs1;
                n_out.immediate    = w_imm_i;
                n_out.operation    = f_op_load(w_f3);
                n_out.format_class = (n_out.operation != OP_NONE) ? FMT_I : FMT_UNDEF;
            end
            OPC_JALR: begin
                if (w_f3 == 3'd0) begin
                    n_out.format_class = FMT_I;
                    n_out.operation    = OP_JALR;
                    n_out.dest_reg     = w_rd;
                    n_out.src1_reg     = w_rs1;
                    n_out.immediate    = w_imm_i;
                end
            end
            OPC_STORE: begin
                n_out.src1_reg     = w_rs1;
                n_out.src2_reg     = w_rs2;
                n_out.immediate    = w_imm_s;
                n_out.operation    = f_op_store(w_f3);
                n_out.format_class = (n_out.operation != OP_NONE) ? FMT_S : FMT_UNDEF;
            end
            OPC_BRANCH: begin
                n_out.src1_reg     = w_rs1;
                n_out.src2_reg     = w_rs2;
                n_out.immediate    = w_imm_b;
                n_out.operation    = f_op_branch(w_f3);
                n_out.format_class = (n_out.operation != OP_NONE) ? FMT_B : FMT_UNDEF;
            end
            OPC_LUI: begin
                n_out.format_class = FMT_U;
                n_out.operation    = OP_LUI;
                n_out.dest_reg     = w_rd;
                n_out.immediate    = {r_word[31:12], 12'h000};
            end
            OPC_AUIPC: begin
                n_out.format_class = FMT_U;
                n_out.operation    = OP_AUIPC;
                n_out.dest_reg     = w_rd;
                n_out.immediate    = {r_word[31:12], 12'h000};
            end
            OPC_JAL: begin
                n_out.format_class = FMT_J;
                n_out.operation    = OP_JAL;
                n_out.dest_reg     = w_rd;
                n_out.immediate    = w_imm_j;
            end
            OPC_MISC_MEM: begin
                if (w_rd == 5'd0 && w_rs1 == 5'd0) begin
                    if (w_f3 == 3'd0 && r_word[31:28] == 4'd0) begin
                        n_out.format_class = FMT_FENCE;
                        n_out.operation    = OP_FENCE;
                        n_out.fence_pred   = r_word[27:24];
                        n_out.fence_succ   = r_word[23:20];
                    end else if (w_f3 == 3'd1 && r_word[31:20] == 12'd0) begin
                        n_out.format_class = FMT_FENCE;
                        n_out.operation    = OP_FENCEI;
                    end
                end
            end
            OPC_SYSTEM: begin
                if (r_word == WORD_ECALL) begin
                    n_out.format_class = FMT_ENV;
                    n_out.operation    = OP_ECALL;
                end else if (r_word == WORD_EBREAK) begin
                    n_out.format_class = FMT_ENV;
                    n_out.operation    = OP_EBREAK;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_instr.valid && i_instr.ready) |=> r_in_valid)
        else $error("Accepted transaction did not reach the input register.");

    a_stage_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_ready) |=> r_out_valid)
        else $error("Decoded transaction did not reach the result register.");

    a_undef_has_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.operation == OP_NONE) |->
        (r_out.format_class == FMT_UNDEF || r_out.format_class == FMT_R))
        else $error("Undefined operation carries a defined format class.");

    a_fence_sets_only_on_fence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.fence_pred != 4'd0 || r_out.fence_succ != 4'd0)) |->
        (r_out.operation == OP_FENCE))
        else $error("Fence sets reported for a non-FENCE instruction.");

    a_upper_imm_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.format_class == FMT_U) |->
        (r_out.immediate[11:0] == 12'h000))
        else $error("Upper immediate has nonzero low bits.");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the RV32I instruction decoder: a directed table, then random words.
`timescale 1ns / 1ps

module testbench;
    import rv32i_dec_pkg::*;

    localparam int RANDOM_WORDS  = 1025;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [31:0] word;
        bit          typed;
        t_dec_out    res;
    } t_vec_row;

    typedef struct {
        logic [31:0] word;
        t_dec_out    res;
    } t_pending_decode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rv32i_dec_stream_if #(.t_payload(t_dec_in))  instr_ch ();
    rv32i_dec_stream_if #(.t_payload(t_dec_out)) dec_ch ();

    rv32i_instruction_decoder_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_instr(instr_ch),
        .o_dec  (dec_ch)
    );

    t_pending_decode expected_decodes[$];
    t_pending_decode offered;
    int              decodes_seen = 0;
    int              mismatches   = 0;
    int              idle_cycles  = 0;
    bit              sink_holding = 1'b0;
    int              send_stretch = 0;
    bit              send_quiet   = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_dec_out decode_instr(input logic [31:0] w);
        t_dec_out    r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        r     = '0;
        case (opc)
            OPC_OP: begin
                r.format_class = FMT_R;
                r.dest_reg     = w[11:7];
                r.src1_reg     = w[19:15];
                r.src2_reg     = w[24:20];
                if (f7 == F7_ZERO) begin
                    case (f3)
                        3'd0:    r.operation = OP_ADD;
                        3'd1:    r.operation = OP_SLL;
                        3'd2:    r.operation = OP_SLT;
                        3'd3:    r.operation = OP_SLTU;
                        3'd4:    r.operation = OP_XOR;
                        3'd5:    r.operation = OP_SRL;
                        3'd6:    r.operation = OP_OR;
                        default: r.operation = OP_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    r.operation = OP_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    r.operation = OP_SRA;
                end
            end
            OPC_OP_IMM: begin
                r.format_class = FMT_I;
                r.dest_reg     = w[11:7];
                r.src1_reg     = w[19:15];
                r.immediate    = imm_i;
                if (f3 == 3'd1 || f3 == 3'd5) begin
                    if (f7 == F7_ZERO) begin
                        r.operation = (f3 == 3'd1) ? OP_SLLI : OP_SRLI;
                    end else if (f7 == F7_ALT && f3 == 3'd5) begin
                        r.operation = OP_SRAI;
                    end
                    if (r.operation != OP_NONE) begin
                        r.format_class = FMT_R;
                        r.src2_reg     = w[24:20];
                    end else begin
                        r.format_class = FMT_UNDEF;
                    end
                end else begin
                    case (f3)
                        3'd0:    r.operation = OP_ADDI;
                        3'd2:    r.operation = OP_SLTI;
                        3'd3:    r.operation = OP_SLTIU;
                        3'd4:    r.operation = OP_XORI;
                        3'd6:    r.operation = OP_ORI;
                        default: r.operation = OP_ANDI;
                    endcase
                end
            end
            OPC_LOAD: begin
                r.dest_reg  = w[11:7];
                r.src1_reg  = w[19:15];
                r.immediate = imm_i;
                case (f3)
                    3'd0:    r.operation = OP_LB;
                    3'd1:    r.operation = OP_LH;
                    3'd2:    r.operation = OP_LW;
                    3'd4:    r.operation = OP_LBU;
                    3'd5:    r.operation = OP_LHU;
                    default: r.operation = OP_NONE;
                endcase
                r.format_class = (r.operation != OP_NONE) ? FMT_I : FMT_UNDEF;
            end
            OPC_JALR: begin
                if (f3 == 3'd0) begin
                    r.format_class = FMT_I;
                    r.operation    = OP_JALR;
                    r.dest_reg     = w[11:7];
                    r.src1_reg     = w[19:15];
                    r.immediate    = imm_i;
                end
            end
            OPC_STORE: begin
                r.src1_reg  = w[19:15];
                r.src2_reg  = w[24:20];
                r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    3'd0:    r.operation = OP_SB;
                    3'd1:    r.operation = OP_SH;
                    3'd2:    r.operation = OP_SW;
                    default: r.operation = OP_NONE;
                endcase
                r.format_class = (r.operation != OP_NONE) ? FMT_S : FMT_UNDEF;
            end
            OPC_BRANCH: begin
                r.src1_reg  = w[19:15];
                r.src2_reg  = w[24:20];
                r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    3'd0:    r.operation = OP_BEQ;
                    3'd1:    r.operation = OP_BNE;
                    3'd4:    r.operation = OP_BLT;
                    3'd5:    r.operation = OP_BGE;
                    3'd6:    r.operation = OP_BLTU;
                    3'd7:    r.operation = OP_BGEU;
                    default: r.operation = OP_NONE;
                endcase
                r.format_class = (r.operation != OP_NONE) ? FMT_B : FMT_UNDEF;
            end
            OPC_LUI, OPC_AUIPC: begin
                r.format_class = FMT_U;
                r.operation    = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
                r.dest_reg     = w[11:7];
                r.immediate    = {w[31:12], 12'h000};
            end
            OPC_JAL: begin
                r.format_class = FMT_J;
                r.operation    = OP_JAL;
                r.dest_reg     = w[11:7];
                r.immediate    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_MISC_MEM: begin
                if (w[11:7] == 5'd0 && w[19:15] == 5'd0) begin
                    if (f3 == 3'd0 && w[31:28] == 4'd0) begin
                        r.format_class = FMT_FENCE;
                        r.operation    = OP_FENCE;
                        r.fence_pred   = w[27:24];
                        r.fence_succ   = w[23:20];
                    end else if (f3 == 3'd1 && w[31:20] == 12'd0) begin
                        r.format_class = FMT_FENCE;
                        r.operation    = OP_FENCEI;
                    end
                end
            end
            OPC_SYSTEM: begin
                if (w == WORD_ECALL) begin
                    r.format_class = FMT_ENV;
                    r.operation    = OP_ECALL;
                end else if (w == WORD_EBREAK) begin
                    r.format_class = FMT_ENV;
                    r.operation    = OP_EBREAK;
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] encode_instr(input logic [5:0] op);
        logic [31:0] w;
        logic [2:0]  f3;
        logic [6:0]  f7;
        bit          has_f7;
        w      = $urandom;
        f3     = 3'd0;
        f7     = F7_ZERO;
        has_f7 = 1'b0;
        case (op)
            OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR,
            OP_AND: begin
                w[6:0] = OPC_OP;
                has_f7 = 1'b1;
                f7     = (op == OP_SUB || op == OP_SRA) ? F7_ALT : F7_ZERO;
            end
            OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_SRAI, OP_ORI,
            OP_ANDI: begin
                w[6:0] = OPC_OP_IMM;
                has_f7 = (op == OP_SLLI || op == OP_SRLI || op == OP_SRAI);
                f7     = (op == OP_SRAI) ? F7_ALT : F7_ZERO;
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                w[6:0] = OPC_LOAD;
            end
            OP_JALR: begin
                w[6:0] = OPC_JALR;
            end
            OP_SB, OP_SH, OP_SW: begin
                w[6:0] = OPC_STORE;
            end
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
                w[6:0] = OPC_BRANCH;
            end
            OP_LUI:    return {w[31:7], OPC_LUI};
            OP_AUIPC:  return {w[31:7], OPC_AUIPC};
            OP_JAL:    return {w[31:7], OPC_JAL};
            OP_FENCE:  return {4'h0, w[27:20], 13'h0000, OPC_MISC_MEM};
            OP_FENCEI: return {17'h00000, 3'd1, 5'd0, OPC_MISC_MEM};
            OP_ECALL:  return WORD_ECALL;
            OP_EBREAK: return WORD_EBREAK;
            default:   return w;
        endcase
        case (op)
            OP_SLL, OP_SLLI, OP_LH, OP_SH, OP_BNE:                  f3 = 3'd1;
            OP_SLT, OP_SLTI, OP_LW, OP_SW:                          f3 = 3'd2;
            OP_SLTU, OP_SLTIU:                                      f3 = 3'd3;
            OP_XOR, OP_XORI, OP_LBU, OP_BLT:                        f3 = 3'd4;
            OP_SRL, OP_SRA, OP_SRLI, OP_SRAI, OP_LHU, OP_BGE:       f3 = 3'd5;
            OP_OR, OP_ORI, OP_BLTU:                                 f3 = 3'd6;
            OP_AND, OP_ANDI, OP_BGEU:                               f3 = 3'd7;
            default:                                                f3 = 3'd0;
        endcase
        w[14:12] = f3;
        if (has_f7) begin
            w[31:25] = f7;
        end
        return w;
    endfunction

    function automatic t_dec_out known_decode(input logic [3:0] fmt, input logic [5:0] op,
                                              input logic [4:0] rd, input logic [31:0] imm,
                                              input logic [3:0] pred, input logic [3:0] succ);
        t_dec_out r;
        r              = '0;
        r.format_class = fmt;
        r.operation    = op;
        r.dest_reg     = rd;
        r.immediate    = imm;
        r.fence_pred   = pred;
        r.fence_succ   = succ;
        return r;
    endfunction

    function automatic t_vec_row vec_row(input logic [31:0] w, input bit typed,
                                         input t_dec_out res);
        t_vec_row v;
        v.word  = w;
        v.typed = typed;
        v.res   = res;
        return v;
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_word(input logic [31:0] w, input t_dec_out want);
        int gap;
        if (send_stretch == 0) begin
            send_stretch = $urandom_range(8, 64);
            send_quiet   = ($urandom_range(0, 2) == 0);
        end
        send_stretch--;
        gap = (send_quiet || sink_holding) ? 0 : random_gap();
        if (gap > 0) begin
            instr_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        instr_ch.valid           = 1'b1;
        instr_ch.payload         = w;
        offered.word             = w;
        offered.res              = want;
        do @(posedge i_clk); while (!instr_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_decodes();
        instr_ch.valid = 1'b0;
        while (expected_decodes.size() != 0) @(negedge i_clk);
    endtask

    task automatic compare_decode(input t_dec_out got, input t_pending_decode want);
        if (got.format_class !== want.res.format_class || got.operation !== want.res.operation
            || got.dest_reg !== want.res.dest_reg || got.src1_reg !== want.res.src1_reg
            || got.src2_reg !== want.res.src2_reg || got.immediate !== want.res.immediate
            || got.fence_pred !== want.res.fence_pred
            || got.fence_succ !== want.res.fence_succ) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("Mismatch on word %h: expected fmt %0d op %0d rd %0d rs1 %0d rs2 %0d",
                         want.word, want.res.format_class, want.res.operation,
                         want.res.dest_reg, want.res.src1_reg, want.res.src2_reg);
                $display("    imm %h pred %h succ %h; got fmt %0d op %0d rd %0d rs1 %0d",
                         want.res.immediate, want.res.fence_pred, want.res.fence_succ,
                         got.format_class, got.operation, got.dest_reg, got.src1_reg);
                $display("    rs2 %0d imm %h pred %h succ %h", got.src2_reg, got.immediate,
                         got.fence_pred, got.fence_succ);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (dec_ch.valid && dec_ch.ready) begin
                decodes_seen++;
                if (expected_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Unexpected result transaction: fmt %0d op %0d",
                                 dec_ch.payload.format_class, dec_ch.payload.operation);
                    end
                end else begin
                    compare_decode(dec_ch.payload, expected_decodes.pop_front());
                end
            end
            if (instr_ch.valid && instr_ch.ready) begin
                expected_decodes.push_back(offered);
            end
            if ((dec_ch.valid && dec_ch.ready) || (instr_ch.valid && instr_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // The sink holds off once for a long stretch so the pipeline fills and stalls its input.
    initial begin
        int  stall_left;
        bit  held;
        dec_ch.ready = 1'b0;
        stall_left   = 0;
        held         = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && decodes_seen >= HOLD_AFTER) begin
                held         = 1'b1;
                sink_holding = 1'b1;
                dec_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                sink_holding = 1'b0;
                stall_left   = 0;
            end
            if (stall_left > 0) begin
                dec_ch.ready = 1'b0;
                stall_left--;
            end else begin
                dec_ch.ready = 1'b1;
                stall_left   = ($urandom_range(0, 3) == 0) ? 0 : random_gap();
            end
        end
    end

    initial begin
        t_vec_row    rows[$];
        logic [31:0] w;
        int          pick;
        int          flip;
        instr_ch.valid   = 1'b0;
        instr_ch.payload = '0;
        offered.word     = '0;
        offered.res      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows.push_back(vec_row(32'h0000_0000, 1'b1,
                               known_decode(FMT_UNDEF, OP_NONE, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'hFFFF_FFFF, 1'b1,
                               known_decode(FMT_UNDEF, OP_NONE, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(WORD_ECALL, 1'b1,
                               known_decode(FMT_ENV, OP_ECALL, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(WORD_EBREAK, 1'b1,
                               known_decode(FMT_ENV, OP_EBREAK, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'h0000_00F3, 1'b1,
                               known_decode(FMT_UNDEF, OP_NONE, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'h0000_100F, 1'b1,
                               known_decode(FMT_FENCE, OP_FENCEI, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'h0FF0_000F, 1'b1,
                               known_decode(FMT_FENCE, OP_FENCE, 5'd0, 32'h0, 4'hF, 4'hF)));
        rows.push_back(vec_row(32'h8FF0_000F, 1'b1,
                               known_decode(FMT_UNDEF, OP_NONE, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'h0FF0_008F, 1'b1,
                               known_decode(FMT_UNDEF, OP_NONE, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'hFFFF_9FE7, 1'b1,
                               known_decode(FMT_UNDEF, OP_NONE, 5'd0, 32'h0, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'hFFFF_F0B7, 1'b1,
                               known_decode(FMT_U, OP_LUI, 5'd1, 32'hFFFF_F000, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'h8000_0F97, 1'b1,
                               known_decode(FMT_U, OP_AUIPC, 5'd31, 32'h8000_0000, 4'h0, 4'h0)));
        rows.push_back(vec_row(32'h01FF_8FB3, 1'b0, '0));
        rows.push_back(vec_row(32'h4000_0033, 1'b0, '0));
        rows.push_back(vec_row(32'hFE00_0033, 1'b0, '0));
        rows.push_back(vec_row(32'h7FF0_0013, 1'b0, '0));
        rows.push_back(vec_row(32'h8000_0013, 1'b0, '0));
        rows.push_back(vec_row(32'h41F0_5013, 1'b0, '0));
        rows.push_back(vec_row(32'h0200_1013, 1'b0, '0));
        rows.push_back(vec_row(32'hFFF0_2003, 1'b0, '0));
        rows.push_back(vec_row(32'h0000_3003, 1'b0, '0));
        rows.push_back(vec_row(32'hFFFF_8FE7, 1'b0, '0));
        rows.push_back(vec_row(32'hFE00_2FA3, 1'b0, '0));
        rows.push_back(vec_row(32'hFE00_0FE3, 1'b0, '0));
        rows.push_back(vec_row(32'h8000_006F, 1'b0, '0));

        foreach (rows[k]) begin
            offer_word(rows[k].word, rows[k].typed ? rows[k].res : decode_instr(rows[k].word));
        end
        drain_decodes();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                drain_decodes();
            end
            w    = encode_instr(6'($urandom_range(OP_ADD, OP_EBREAK)));
            pick = $urandom_range(0, 99);
            if (pick >= 96) begin
                w[31:7] = 25'($urandom);
            end else if (pick >= 92) begin
                flip    = $urandom_range(0, 31);
                w[flip] = ~w[flip];
            end else if (pick >= 88) begin
                w[31:25] = 7'($urandom_range(0, 127));
            end else if (pick >= 84) begin
                w[14:12] = 3'($urandom_range(0, 7));
            end else if (pick >= 80) begin
                w = $urandom;
            end
            offer_word(w, decode_instr(w));
        end
        drain_decodes();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_decodes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
sv/rv32i_dec_pkg.sv
sv/rv32i_dec_stream_if.sv
sv/rv32i_instruction_decoder_top.sv
tb/testbench.sv
